// File: rtl/lut3d_pkg.sv
// shared types and constants of the 3d lut color mapper
package lut3d_pkg;

  localparam int MAX_GRID    = 33;
  localparam int ENTRY_BITS  = 16;
  localparam int GRID_W      = 6;
  localparam int STORE_DEPTH = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int ADDR_W      = 16;
  localparam int FIELD_W     = 16;
  localparam int PIX_W       = 8;
  localparam int TDATA_IN_W  = 4 * FIELD_W + 3 * PIX_W;
  localparam int TDATA_OUT_W = 3 * PIX_W;
  localparam int ENTRY_W     = 3 * ENTRY_BITS;
  localparam int WT_W        = 3 * PIX_W;
  localparam int PROD_W      = ENTRY_BITS + WT_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // rounding divide by reciprocal: top bits of the numerator times RECIP
  localparam int RECIP_W     = 17;
  localparam int RPROD_W     = 2 * RECIP_W;
  localparam int XH_SHIFT    = ACC_W - RECIP_W;
  localparam int QE_SHIFT    = 24;
  localparam int QE_W        = PIX_W + 1;

  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(MAX_GRID);
  localparam logic [GRID_W-1:0] GRID_MIN   = GRID_W'(2);
  localparam logic [ACC_W-1:0]  DENOM      =
    ACC_W'(((64'd1 << ENTRY_BITS) - 64'd1) * 64'd65025);
  localparam logic [ACC_W-1:0]  DIV_M      = DENOM << 1;
  localparam logic [RECIP_W-1:0] RECIP     =
    RECIP_W'((64'd1 << (XH_SHIFT + QE_SHIFT)) / (64'(DENOM) << 1));

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PIXEL = 1'b1
  } kind_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  idx;
    logic [ENTRY_W-1:0] data;
  } load_t;

endpackage

// File: rtl/lut3d_ram.sv
// generic ram, one write port and two registered read ports
module lut3d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/lut3d_trilinear_color_map_core.sv
// 3d lut color mapper with trilinear blend, pipelined core
//
//  channel        | dir | payload
//  ---------------+-----+------------------------------------------------
//  s_axis         | in  | tuser kind, tdata index/entry rgb/pixel rgb
//  m_axis         | out | tdata mapped rgb bytes
//  grid_points_*  | in  | grid size register, write only
//
//  one request per cycle enters while s_axis_tready is high (output fifo credit free)
//  the pipeline holds the corner address multiplies, the ram read and the
//  rounding divide: reciprocal multiply, quotient times divisor, one correction
//  reset clears valid bits, fifo pointers and sets grid size to 33
//  a 16 entry output fifo with credit count holds results during stalls
module lut3d_trilinear_color_map_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 grid_points_we_i,
  input  logic [lut3d_pkg::GRID_W-1:0]         grid_points_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // index, entry_red, entry_green, entry_blue, pixel_red, pixel_green, pixel_blue
  input  logic [lut3d_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // kind
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_red, out_green, out_blue
  output logic [lut3d_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

  import lut3d_pkg::*;

  logic [GRID_W-1:0] grid_q;
  logic [GRID_W-1:0] n;
  logic [GRID_W-1:0] nm1;
  logic              accept;
  kind_e             kind_in;
  load_t             ld_in;

  logic [PIX_W-1:0]  pix     [3];
  logic [13:0]       scaled  [3];
  logic [15:0]       lo_t    [3];
  logic [GRID_W-1:0] lo_c    [3];
  logic [GRID_W-1:0] hi_c    [3];
  logic [PIX_W-1:0]  w_c     [3];

  logic              v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  kind_e             k1_q, k2_q, k3_q;
  load_t             ld1_q, ld2_q, ld3_q;
  logic [GRID_W-1:0] lo1_q [3];
  logic [GRID_W-1:0] hi1_q [3];
  logic [PIX_W-1:0]  w1_q  [3];

  logic [2*GRID_W-1:0] rn2_q  [2];
  logic [GRID_W-1:0]   g2_q   [2];
  logic [GRID_W-1:0]   b2_q   [2];
  logic [15:0]         wrg2_q [4];
  logic [PIX_W-1:0]    wb2_q;

  logic [ADDR_W-1:0] addr3_q [8];
  logic [WT_W-1:0]   wk3_q   [8];
  logic              ram_we;

  logic [ENTRY_W-1:0] rdat [8];
  logic [WT_W-1:0]    wk4_q [8];
  logic [PROD_W-1:0]  prod5_q [3][8];
  logic [ACC_W-1:0]   s6_q [3][2];
  logic [ACC_W-1:0]   x7_q [3];
  logic [ACC_W-1:0]   x8_q [3];
  logic [RPROD_W-1:0] p8_q [3];
  logic [ACC_W-1:0]   x9_q [3];
  logic [QE_W-1:0]    qe9_q [3];
  logic [ACC_W-1:0]   qm9_q [3];
  logic [PIX_W-1:0]   q10_q [3];
  logic               vq_q [3];

  logic [TDATA_OUT_W-1:0] fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]  cnt_q, occ_q;
  logic                   push, pop, credit_take;

  function automatic logic [PIX_W-1:0] wsel(logic sel, logic [PIX_W-1:0] w);
    return sel ? w : PIX_W'(255) - w;
  endfunction

  // grid size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (grid_points_we_i) begin
      grid_q <= grid_points_i;
    end
  end

  always_comb begin
    if (grid_q < GRID_MIN) begin
      n = GRID_MIN;
    end else if (grid_q > GRID_W'(MAX_GRID)) begin
      n = GRID_W'(MAX_GRID);
    end else begin
      n = grid_q;
    end
    nm1 = n - GRID_W'(1);
  end

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign kind_in       = kind_e'(s_axis_tuser);
  assign ld_in.idx     = s_axis_tdata[FIELD_W-1:0];
  assign ld_in.data    = {s_axis_tdata[3*FIELD_W +: ENTRY_BITS],
                          s_axis_tdata[2*FIELD_W +: ENTRY_BITS],
                          s_axis_tdata[FIELD_W +: ENTRY_BITS]};
  assign pix[0]        = s_axis_tdata[4*FIELD_W +: PIX_W];
  assign pix[1]        = s_axis_tdata[4*FIELD_W+PIX_W +: PIX_W];
  assign pix[2]        = s_axis_tdata[4*FIELD_W+2*PIX_W +: PIX_W];

  // per axis cell index and weight; upper neighbor clamps at the top edge
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      scaled[a] = 14'({6'd0, pix[a]} * {8'd0, nm1});
      lo_t[a]   = 16'(scaled[a]) + 16'd1 + 16'(scaled[a] >> 8);
      lo_c[a]   = GRID_W'(lo_t[a] >> 8);
      w_c[a]    = PIX_W'(scaled[a] - 14'({8'd0, lo_c[a]} * 14'd255));
      hi_c[a]   = ({1'b0, lo_c[a]} + 7'd1 < {1'b0, n}) ? lo_c[a] + GRID_W'(1)
                                                       : lo_c[a];
    end
  end

  // valid bits of every stage; load requests drop out after stage 3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      for (int s = 0; s < 3; s++) vq_q[s] <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q & (k3_q == KIND_PIXEL);
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vq_q[0] <= v7_q;
      for (int s = 1; s < 3; s++) vq_q[s] <= vq_q[s-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    k1_q  <= kind_in;
    ld1_q <= ld_in;
    for (int a = 0; a < 3; a++) begin
      lo1_q[a] <= lo_c[a];
      hi1_q[a] <= hi_c[a];
      w1_q[a]  <= w_c[a];
    end

    k2_q     <= k1_q;
    ld2_q    <= ld1_q;
    rn2_q[0] <= {{GRID_W{1'b0}}, lo1_q[0]} * {{GRID_W{1'b0}}, n};
    rn2_q[1] <= {{GRID_W{1'b0}}, hi1_q[0]} * {{GRID_W{1'b0}}, n};
    g2_q[0]  <= lo1_q[1];
    g2_q[1]  <= hi1_q[1];
    b2_q[0]  <= lo1_q[2];
    b2_q[1]  <= hi1_q[2];
    wb2_q    <= w1_q[2];
    for (int j = 0; j < 4; j++) begin
      wrg2_q[j] <= {8'd0, wsel(j[1], w1_q[0])} * {8'd0, wsel(j[0], w1_q[1])};
    end

    k3_q  <= k2_q;
    ld3_q <= ld2_q;
    for (int k = 0; k < 8; k++) begin
      addr3_q[k] <= ADDR_W'(
        (19'(rn2_q[k[2]]) + 19'(g2_q[k[1]])) * 19'(n) + 19'(b2_q[k[0]]));
      wk3_q[k]   <= WT_W'({8'd0, wrg2_q[k[2:1]]} * {16'd0, wsel(k[0], wb2_q)});
    end

    for (int k = 0; k < 8; k++) wk4_q[k] <= wk3_q[k];

    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 8; k++) begin
        prod5_q[c][k] <= {{WT_W{1'b0}}, rdat[k][c*ENTRY_BITS +: ENTRY_BITS]}
                       * {{ENTRY_BITS{1'b0}}, wk4_q[k]};
      end
      for (int h = 0; h < 2; h++) begin
        s6_q[c][h] <= ACC_W'(prod5_q[c][4*h]) + ACC_W'(prod5_q[c][4*h+1])
                    + ACC_W'(prod5_q[c][4*h+2]) + ACC_W'(prod5_q[c][4*h+3]);
      end
      x7_q[c]  <= ((s6_q[c][0] + s6_q[c][1]) << 1) + DENOM;
      // quotient estimate, low by at most one
      x8_q[c]  <= x7_q[c];
      p8_q[c]  <= RPROD_W'(x7_q[c][ACC_W-1 -: RECIP_W]) * RPROD_W'(RECIP);
      x9_q[c]  <= x8_q[c];
      qe9_q[c] <= QE_W'(p8_q[c] >> QE_SHIFT);
      qm9_q[c] <= ACC_W'(QE_W'(p8_q[c] >> QE_SHIFT)) * DIV_M;
      q10_q[c] <= (x9_q[c] - qm9_q[c] >= DIV_M) ? PIX_W'(qe9_q[c] + QE_W'(1))
                                                : PIX_W'(qe9_q[c]);
    end
  end

  // cube store, replicated so each corner has its own read port
  assign ram_we = v3_q & (k3_q == KIND_LOAD) & ({1'b0, ld3_q.idx} < 17'(STORE_DEPTH));

  for (genvar i = 0; i < 4; i++) begin : g_ram
    lut3d_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk_i     (clk_i),
      .we_i      (ram_we),
      .waddr_i   (ld3_q.idx),
      .wdata_i   (ld3_q.data),
      .raddr_a_i (addr3_q[2*i]),
      .raddr_b_i (addr3_q[2*i+1]),
      .rdata_a_o (rdat[2*i]),
      .rdata_b_o (rdat[2*i+1])
    );
  end

  // output fifo with credit count
  assign push          = vq_q[2];
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign credit_take   = accept & (kind_in == KIND_PIXEL);
  assign s_axis_tready = occ_q < FIFO_CNT_W'(FIFO_DEPTH);
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {q10_q[2], q10_q[1], q10_q[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      occ_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      occ_q <= occ_q + FIFO_CNT_W'(credit_take) - FIFO_CNT_W'(pop);
    end
  end

endmodule

// File: sim/testbench.sv
// testbench for the 3d lut trilinear color mapper core
module testbench;
  import lut3d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 5000;
  localparam int NUM_PHASES    = 9;
  localparam int RAND_ITEMS    = 90;

  typedef struct packed {
    kind_e                 kind;
    logic [TDATA_IN_W-1:0] data;
  } request_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    grid_points_we_i;
  logic [GRID_W-1:0]       grid_points_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [TDATA_IN_W-1:0]   s_axis_tdata;
  logic                    s_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [TDATA_OUT_W-1:0]  m_axis_tdata;

  request_t               pending_q[$];
  logic [TDATA_OUT_W-1:0] mapped_q[$];
  logic [ENTRY_W-1:0]     cube_mem [0:STORE_DEPTH-1];
  logic [GRID_W-1:0]      grid_reg;
  request_t               next_req;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  logic                   send_hold;
  int                     errors;
  int                     pixels_checked;
  int                     loads_sent;
  int                     stall_cnt;

  lut3d_trilinear_color_map_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grid_points_we_i (grid_points_we_i),
    .grid_points_i    (grid_points_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned grid_size();
    if (grid_reg < 2) return 2;
    if (grid_reg > MAX_GRID) return MAX_GRID;
    return grid_reg;
  endfunction

  // lattice coordinates near either end of an axis, the ones queue_edge_loads loads
  function automatic logic on_edge(int unsigned v, int unsigned n);
    return (v <= 1) || (v + 2 >= n);
  endfunction

  // random pixel byte whose two neighbors on the axis are both loaded
  function automatic logic [PIX_W-1:0] pick_chan(int unsigned n);
    int unsigned c;
    int unsigned s;
    int unsigned lo;
    int unsigned hi;
    do begin
      c  = $urandom_range(255);
      s  = c * (n - 1);
      lo = s / 255;
      hi = (lo + 1 < n) ? lo + 1 : n - 1;
    end while (!(on_edge(lo, n) && on_edge(hi, n)));
    return PIX_W'(c);
  endfunction

  function automatic logic [TDATA_OUT_W-1:0] blend_pixel(logic [PIX_W-1:0] pr,
                                                        logic [PIX_W-1:0] pg,
                                                        logic [PIX_W-1:0] pb);
    int unsigned     n;
    int unsigned     lo[3];
    int unsigned     hi[3];
    int unsigned     w[3];
    int unsigned     c[3];
    int unsigned     addr;
    longint unsigned acc;
    longint unsigned den;
    longint unsigned q;
    logic [ENTRY_W-1:0] ent;
    logic [TDATA_OUT_W-1:0] res;
    n = grid_size();
    c[0] = pr; c[1] = pg; c[2] = pb;
    den = 64'd65535 * 64'd65025;
    for (int a = 0; a < 3; a++) begin
      lo[a] = (c[a] * (n - 1)) / 255;
      w[a]  = (c[a] * (n - 1)) % 255;
      hi[a] = (lo[a] + 1 < n) ? lo[a] + 1 : n - 1;
    end
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int k = 0; k < 8; k++) begin
        addr = (((k & 4) ? hi[0] : lo[0]) * n + ((k & 2) ? hi[1] : lo[1])) * n
               + ((k & 1) ? hi[2] : lo[2]);
        ent = cube_mem[addr];
        acc += longint'(ent[ch*ENTRY_BITS +: ENTRY_BITS])
               * ((k & 4) ? w[0] : 255 - w[0])
               * ((k & 2) ? w[1] : 255 - w[1])
               * ((k & 1) ? w[2] : 255 - w[2]);
      end
      q = (2 * acc + den) / (2 * den);
      if (q > 255) q = 255;
      res[ch*PIX_W +: PIX_W] = q[PIX_W-1:0];
    end
    return res;
  endfunction

  function automatic request_t make_req(kind_e kind, int unsigned idx,
                                        logic [ENTRY_W-1:0] ent,
                                        logic [PIX_W-1:0] pr, logic [PIX_W-1:0] pg,
                                        logic [PIX_W-1:0] pb);
    request_t r;
    r.kind = kind;
    r.data = {pb, pg, pr, ent, idx[ADDR_W-1:0]};
    return r;
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_entry();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic request_t rand_pixel();
    int unsigned n;
    n = grid_size();
    return make_req(KIND_PIXEL, $urandom, rand_entry(), pick_chan(n), pick_chan(n),
                    pick_chan(n));
  endfunction

  // load every entry whose corner coordinates are all near an axis end
  task automatic queue_edge_loads();
    int unsigned n;
    n = grid_size();
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned g = 0; g < n; g++)
        for (int unsigned b = 0; b < n; b++)
          if (on_edge(r, n) && on_edge(g, n) && on_edge(b, n)) begin
            pending_q.push_back(make_req(KIND_LOAD, (r * n + g) * n + b, rand_entry(),
                                         PIX_W'($urandom), 8'd0, 8'd0));
            loads_sent++;
          end
  endtask

  // apply accepted request to the shadow cube and queue the mapped pixel
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == KIND_LOAD) begin
        if (s_axis_tdata[ADDR_W-1:0] < STORE_DEPTH)
          cube_mem[s_axis_tdata[ADDR_W-1:0]] = s_axis_tdata[ADDR_W +: ENTRY_W];
      end else begin
        mapped_q.push_back(blend_pixel(s_axis_tdata[ADDR_W+ENTRY_W +: PIX_W],
                                       s_axis_tdata[ADDR_W+ENTRY_W+PIX_W +: PIX_W],
                                       s_axis_tdata[ADDR_W+ENTRY_W+2*PIX_W +: PIX_W]));
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() != 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_req.data;
        s_axis_tuser  <= next_req.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mapped_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        for (int ch = 0; ch < 3; ch++)
          if (m_axis_tdata[ch*PIX_W +: PIX_W] !== mapped_q[0][ch*PIX_W +: PIX_W]) begin
            $display("%0t: channel %0d expected %h actual %h", $time, ch,
                     mapped_q[0][ch*PIX_W +: PIX_W], m_axis_tdata[ch*PIX_W +: PIX_W]);
            errors++;
          end
        void'(mapped_q.pop_front());
        pixels_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic settle();
    while (pending_q.size() != 0 || s_axis_tvalid || mapped_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [GRID_W-1:0] val);
    @(posedge clk_i);
    grid_points_we_i <= 1'b1;
    grid_points_i    <= val;
    grid_reg = val;
    @(posedge clk_i);
    grid_points_we_i <= 1'b0;
  endtask

  initial begin
    logic [GRID_W-1:0] grids[NUM_PHASES];
    int                mode;
    rst_ni = 1'b0;
    grid_points_we_i = 1'b0;
    grid_points_i = '0;
    send_idle_pct = 27;
    recv_idle_pct = 86;
    send_hold = 1'b0;
    errors = 0;
    pixels_checked = 0;
    loads_sent = 0;
    stall_cnt = 0;
    grid_reg = GRID_RESET;
    grids = '{6'd33, 6'd2, 6'd0, 6'd17, 6'd63, 6'd1, 6'd5, 6'd34, 6'd9};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = ph * 3 / NUM_PHASES;
      send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 86 : 0;
      recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 27 : 0;
      write_grid(grids[ph]);
      // every lookup of this phase lands on an entry loaded here
      queue_edge_loads();
      if (ph == 0) begin
        for (int k = 0; k < 8; k++)
          pending_q.push_back(make_req(KIND_PIXEL, 0, '0, (k & 4) ? 8'd255 : 8'd0,
                                       (k & 2) ? 8'd255 : 8'd0, (k & 1) ? 8'd255 : 8'd0));
        pending_q.push_back(make_req(KIND_PIXEL, 0, '0, 8'd255, 8'd1, 8'd254));
        pending_q.push_back(make_req(KIND_PIXEL, 0, '0, 8'd7, 8'd248, 8'd0));
        pending_q.push_back(make_req(KIND_LOAD, 0, '1, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_LOAD, STORE_DEPTH - 1, '1, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_LOAD, STORE_DEPTH, '0, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_LOAD, 65535, '0, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_PIXEL, 0, '0, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_PIXEL, 0, '0, 8'd255, 8'd255, 8'd255));
        pending_q.push_back(make_req(KIND_LOAD, 0, '0, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_LOAD, STORE_DEPTH - 1, '0, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_PIXEL, 0, '0, 8'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(KIND_PIXEL, 0, '0, 8'd255, 8'd255, 8'd255));
        loads_sent += 6;
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if ($urandom_range(3) == 0) begin
          pending_q.push_back(make_req(KIND_LOAD, ($urandom_range(1) != 0) ?
                                       $urandom_range(STORE_DEPTH - 1) : $urandom_range(65535),
                                       rand_entry(), PIX_W'($urandom), PIX_W'($urandom),
                                       PIX_W'($urandom)));
          loads_sent++;
        end else begin
          pending_q.push_back(rand_pixel());
        end
      end
      if (ph == 4) begin
        // hold the stream until all mapped pixels are back
        while (pending_q.size() > RAND_ITEMS / 2) @(posedge clk_i);
        send_hold <= 1'b1;
        while (mapped_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        @(posedge clk_i);
        send_hold <= 1'b0;
      end
      settle();
    end

    $display("covered %0d cube loads and %0d mapped pixels over %0d grid sizes",
             loads_sent, pixels_checked, NUM_PHASES);
    $display("grid sizes included clamped values below 2 and above %0d", MAX_GRID);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lut3d_pkg.sv
rtl/lut3d_ram.sv
rtl/lut3d_trilinear_color_map_core.sv
sim/testbench.sv
